// ----- src/sams_pkg.sv -----
// ----------------------------------------------------------------------------
// sams_pkg
// shared types and constants of the simt active mask stack
// ----------------------------------------------------------------------------
package sams_pkg;

	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_SETACT = 3'd2,
		OP_SETPRD = 3'd3,
		OP_DIGEST = 3'd4,
		OP_QUERY  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNDERFLOW = 2'd2,
		ERR_LANE      = 2'd3
	} err_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] lane;
		logic       bit_value;
		logic [4:0] pop_count;
		logic       lane_ok;
	} req_t;

	localparam logic [31:0] MUL_COUNT = 32'h4919f71f;
	localparam logic [31:0] MUL_ADDR  = 32'h31f2e73b;

	localparam int LANE_COUNT_W = 7;
	localparam logic [LANE_COUNT_W-1:0] LANE_COUNT_RST = 7'd64;

endpackage

// ----- src/sams_ram.sv -----
// ----------------------------------------------------------------------------
// sams_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sams_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/sams_mask_stack.sv -----
// ----------------------------------------------------------------------------
// sams_mask_stack
// active mask stack, predicate mask and stack level with error checks
// ----------------------------------------------------------------------------
module sams_mask_stack #(
	parameter int LANES       = 64,
	parameter int STACK_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  sams_pkg::req_t     req,
	output logic [LANES-1:0]   top_mask,
	output logic [LANES-1:0]   mask_nxt,
	output logic [LANES-1:0]   pred_nxt,
	output logic [4:0]         level_nxt,
	output sams_pkg::err_t     err
);

	localparam int SW = $clog2(STACK_DEPTH);
	localparam int LW = LANES > 1 ? $clog2(LANES) : 1;

	// top row lives in top_mask_q, rows below the top in rows_q
	logic [LANES-1:0] rows_q [STACK_DEPTH];
	logic [LANES-1:0] top_mask_q;
	logic [LANES-1:0] pred_q;
	logic [SW-1:0]    top_q;

	logic [SW-1:0]    top_nxt;
	logic [SW+4:0]    top_x;
	logic [SW+4:0]    cnt_x;
	logic [SW+4:0]    diff_x;
	logic [SW+4:0]    lvl_x;
	logic [SW-1:0]    pop_idx;
	logic [LW-1:0]    lane_idx;
	logic             push_ok;

	assign top_x    = {5'b0, top_q};
	assign cnt_x    = {{SW{1'b0}}, req.pop_count};
	assign diff_x   = top_x - cnt_x;
	assign pop_idx  = diff_x[SW-1:0];
	assign lane_idx = req.lane[LW-1:0];
	assign push_ok  = top_q != SW'(STACK_DEPTH - 1);

	always_comb begin
		mask_nxt = top_mask_q;
		pred_nxt = pred_q;
		top_nxt  = top_q;
		err      = sams_pkg::ERR_NONE;
		case (req.op)
			sams_pkg::OP_PUSH: begin
				if (!push_ok) begin
					err = sams_pkg::ERR_OVERFLOW;
				end else begin
					top_nxt = top_q + SW'(1);
				end
			end
			sams_pkg::OP_POP: begin
				if (req.pop_count != 5'd0) begin
					if (top_x < cnt_x) begin
						err = sams_pkg::ERR_UNDERFLOW;
					end else begin
						top_nxt  = pop_idx;
						mask_nxt = rows_q[pop_idx];
					end
				end
			end
			sams_pkg::OP_SETACT: begin
				if (!req.lane_ok) begin
					err = sams_pkg::ERR_LANE;
				end else begin
					mask_nxt[lane_idx] = req.bit_value;
				end
			end
			sams_pkg::OP_SETPRD: begin
				if (!req.lane_ok) begin
					err = sams_pkg::ERR_LANE;
				end else begin
					pred_nxt[lane_idx] = req.bit_value;
				end
			end
			sams_pkg::OP_DIGEST: begin
				if (!req.lane_ok) begin
					err = sams_pkg::ERR_LANE;
				end
			end
			default: begin
			end
		endcase
	end

	assign lvl_x     = {5'b0, top_nxt};
	assign level_nxt = lvl_x[4:0];
	assign top_mask  = top_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q      <= '0;
			top_mask_q <= '0;
			pred_q     <= '0;
		end else if (fire) begin
			top_q      <= top_nxt;
			top_mask_q <= mask_nxt;
			pred_q     <= pred_nxt;
		end
	end

	// push saves the current top row below the new top
	always_ff @(posedge clk) begin
		if (fire && req.op == sams_pkg::OP_PUSH && push_ok) begin
			rows_q[top_q] <= top_mask_q;
		end
	end

endmodule

// ----- src/sams_digest.sv -----
// ----------------------------------------------------------------------------
// sams_digest
// per-lane branch digests with mixing multipliers and write bypass
// ----------------------------------------------------------------------------
module sams_digest #(
	parameter int LANES = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  logic [5:0]     acc_lane,
	input  logic [31:0]    acc_count,
	input  logic [31:0]    acc_addr,
	input  logic           fire,
	input  sams_pkg::req_t req,
	input  logic           active,
	output logic [31:0]    digest_nxt
);

	localparam int LW = LANES > 1 ? $clog2(LANES) : 1;

	logic [LANES-1:0] valid_q;
	logic             vld_s1;
	logic [31:0]      prod_c_s1;
	logic [31:0]      prod_a_s1;
	logic             byp_vld_q;
	logic [LW-1:0]    byp_lane_q;
	logic [31:0]      byp_data_q;

	logic [31:0]      rdata;
	logic [31:0]      cur;
	logic [31:0]      upd;
	logic             wr;
	logic [LW-1:0]    rd_idx;
	logic [LW-1:0]    lane_idx;
	logic             rd_in_range;

	assign rd_idx      = acc_lane[LW-1:0];
	assign lane_idx    = req.lane[LW-1:0];
	assign rd_in_range = {1'b0, acc_lane} < 7'(LANES);

	sams_ram #(
		.WIDTH (32),
		.DEPTH (LANES)
	) u_ram (
		.clk   (clk),
		.we    (wr),
		.waddr (lane_idx),
		.wdata (upd),
		.re    (acc),
		.raddr (rd_idx),
		.rdata (rdata)
	);

	// latest write wins over a read taken at the same edge
	always_comb begin
		if (byp_vld_q && byp_lane_q == lane_idx) begin
			cur = byp_data_q;
		end else if (vld_s1) begin
			cur = rdata;
		end else begin
			cur = '0;
		end
	end

	assign wr  = fire && req.op == sams_pkg::OP_DIGEST && req.lane_ok && active;
	assign upd = cur ^ (prod_c_s1 + prod_a_s1);

	always_comb begin
		if (!req.lane_ok) begin
			digest_nxt = '0;
		end else if (wr) begin
			digest_nxt = upd;
		end else begin
			digest_nxt = cur;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			prod_c_s1 <= acc_count * sams_pkg::MUL_COUNT;
			prod_a_s1 <= acc_addr * sams_pkg::MUL_ADDR;
		end
		if (wr) begin
			byp_lane_q <= lane_idx;
			byp_data_q <= upd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			vld_s1    <= 1'b0;
			byp_vld_q <= 1'b0;
		end else begin
			if (acc) begin
				vld_s1 <= rd_in_range ? valid_q[rd_idx] : 1'b0;
			end
			if (wr) begin
				valid_q[lane_idx] <= 1'b1;
				byp_vld_q         <= 1'b1;
			end
		end
	end

endmodule

// ----- src/simt_active_mask_stack.sv -----
// ----------------------------------------------------------------------------
// simt_active_mask_stack
// branch divergence unit of one simt warp: mask stack, predicates, digests
// ----------------------------------------------------------------------------
// requests arrive on the s_axis channel, one warp control operation each,
// and every request gives exactly one result on the m_axis channel.
// cfg_wen with cfg_wdata sets the number of lanes in use; write it only
// while no request is in flight.
// a request is registered on acceptance and handled once the result
// register is free or being emptied; then the stack, predicate and digest
// state is updated and the result register is loaded, which offers the result.
// one request per cycle is sustained while the receiver takes results;
// the digest ram read, started on acceptance, and the update of all
// state at once when a request is handled make that possible.
// reset empties the stack to level zero with a zero top mask, clears the
// predicates, marks every digest as zero and sets the lane count to 64.
// when the receiver stalls the result is held and one further request is
// taken into the input register; after that s_axis_tready stays low.
// ----------------------------------------------------------------------------
module simt_active_mask_stack #(
	parameter int LANES       = 64,
	parameter int STACK_DEPTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [6:0]   cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// operation, lane, bit_value, pop_count, exec_count, pc, zero pad
	input  logic [79:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// active_mask, pred_mask, lane_digest, stack_level, error, zero pad
	output logic [167:0] m_axis_tdata
);

	logic [sams_pkg::LANE_COUNT_W-1:0] lane_count_q;
	logic [sams_pkg::LANE_COUNT_W-1:0] in_use;

	logic           s1_valid_q;
	sams_pkg::op_t  op_s1;
	logic [5:0]     lane_s1;
	logic           bit_s1;
	logic [4:0]     cnt_s1;

	logic           out_valid_q;
	logic [63:0]    active_q;
	logic [63:0]    pred_q;
	logic [31:0]    digest_q;
	logic [4:0]     level_q;
	sams_pkg::err_t err_q;

	logic           acc;
	logic           fire;
	sams_pkg::req_t req;

	logic [LANES-1:0] top_mask;
	logic [LANES-1:0] mask_nxt;
	logic [LANES-1:0] pred_nxt;
	logic [4:0]       level_nxt;
	sams_pkg::err_t   err_nxt;
	logic [31:0]      digest_nxt;
	logic [LANES-1:0] lane_sel;

	assign fire          = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || fire;
	assign acc           = s_axis_tvalid && s_axis_tready;

	assign in_use = (lane_count_q < 7'(LANES)) ? lane_count_q : 7'(LANES);

	assign req.op        = op_s1;
	assign req.lane      = lane_s1;
	assign req.bit_value = bit_s1;
	assign req.pop_count = cnt_s1;
	assign req.lane_ok   = {1'b0, lane_s1} < in_use;

	assign lane_sel = top_mask >> lane_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_count_q <= sams_pkg::LANE_COUNT_RST;
		end else if (cfg_wen) begin
			lane_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1   <= sams_pkg::op_t'(s_axis_tdata[2:0]);
			lane_s1 <= s_axis_tdata[8:3];
			bit_s1  <= s_axis_tdata[9];
			cnt_s1  <= s_axis_tdata[14:10];
		end
		if (fire) begin
			active_q <= 64'(mask_nxt);
			pred_q   <= 64'(pred_nxt);
			digest_q <= digest_nxt;
			level_q  <= level_nxt;
			err_q    <= err_nxt;
		end
	end

	sams_mask_stack #(
		.LANES       (LANES),
		.STACK_DEPTH (STACK_DEPTH)
	) u_mask_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.req       (req),
		.top_mask  (top_mask),
		.mask_nxt  (mask_nxt),
		.pred_nxt  (pred_nxt),
		.level_nxt (level_nxt),
		.err       (err_nxt)
	);

	sams_digest #(
		.LANES (LANES)
	) u_digest (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.acc_lane   (s_axis_tdata[8:3]),
		.acc_count  (s_axis_tdata[46:15]),
		.acc_addr   (s_axis_tdata[78:47]),
		.fire       (fire),
		.req        (req),
		.active     (lane_sel[0]),
		.digest_nxt (digest_nxt)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, err_q, level_q, digest_q, pred_q, active_q};

endmodule

// ----- tb/mask_stack_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mask_stack_checker
// watches both channels of the mask stack, predicts and compares results
// ----------------------------------------------------------------------------
// keeps its own copy of the mask stack, predicate bits, lane digests and
// lane count. every accepted request is stepped through that copy and the
// status it leaves is queued; every accepted result is compared field by
// field with the oldest queued status.
// ----------------------------------------------------------------------------
module mask_stack_checker
	import sams_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wen,
	input  logic [6:0]   cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [79:0]  s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [167:0] m_tdata,
	output int           fail_count,
	output int           pending,
	output int           checked
);

	localparam int DEPTH = 32;

	typedef struct packed {
		logic [63:0] active;
		logic [63:0] pred;
		logic [31:0] digest;
		logic [4:0]  level;
		err_t        err;
	} warp_status_t;

	logic [63:0]  mask_rows [DEPTH];
	logic [4:0]   top_idx;
	logic [63:0]  pred_bits;
	logic [31:0]  lane_digest [64];
	logic [6:0]   lane_cnt;
	warp_status_t status_q [$];
	int           fails;
	int           compared;

	function automatic warp_status_t step_warp(input logic [79:0] req);
		logic [2:0]   op;
		logic [5:0]   lane;
		logic         bitv;
		logic [4:0]   cnt;
		logic [31:0]  icount;
		logic [31:0]  iaddr;
		logic [31:0]  mix;
		logic [6:0]   in_use;
		logic         lane_ok;
		err_t         err;
		warp_status_t res;
		op      = req[2:0];
		lane    = req[8:3];
		bitv    = req[9];
		cnt     = req[14:10];
		icount  = req[46:15];
		iaddr   = req[78:47];
		in_use  = (lane_cnt < 7'd64) ? lane_cnt : 7'd64;
		lane_ok = {1'b0, lane} < in_use;
		err     = ERR_NONE;
		case (op)
			OP_PUSH: begin
				if (top_idx == 5'(DEPTH - 1)) begin
					err = ERR_OVERFLOW;
				end else begin
					mask_rows[top_idx + 5'd1] = mask_rows[top_idx];
					top_idx = top_idx + 5'd1;
				end
			end
			OP_POP: begin
				if (cnt != 5'd0) begin
					if (top_idx < cnt)
						err = ERR_UNDERFLOW;
					else
						top_idx = top_idx - cnt;
				end
			end
			OP_SETACT: begin
				if (!lane_ok)
					err = ERR_LANE;
				else
					mask_rows[top_idx][lane] = bitv;
			end
			OP_SETPRD: begin
				if (!lane_ok)
					err = ERR_LANE;
				else
					pred_bits[lane] = bitv;
			end
			OP_DIGEST: begin
				if (!lane_ok) begin
					err = ERR_LANE;
				end else if (mask_rows[top_idx][lane]) begin
					mix = icount * MUL_COUNT + iaddr * MUL_ADDR;
					lane_digest[lane] = lane_digest[lane] ^ mix;
				end
			end
			default: begin
			end
		endcase
		res.active = mask_rows[top_idx];
		res.pred   = pred_bits;
		res.digest = lane_ok ? lane_digest[lane] : 32'd0;
		res.level  = top_idx;
		res.err    = err;
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		warp_status_t want;
		warp_status_t got;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				mask_rows[i] = '0;
			for (int i = 0; i < 64; i++)
				lane_digest[i] = '0;
			top_idx    = '0;
			pred_bits  = '0;
			lane_cnt   = LANE_COUNT_RST;
			status_q.delete();
			fails      = 0;
			compared   = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.active = m_tdata[63:0];
				got.pred   = m_tdata[127:64];
				got.digest = m_tdata[159:128];
				got.level  = m_tdata[164:160];
				got.err    = err_t'(m_tdata[166:165]);
				if (status_q.size() == 0) begin
					$display("%0t: result with no request outstanding, expected none, actual %h",
						$time, m_tdata);
					fails++;
				end else begin
					want = status_q.pop_front();
					compare_field("active_mask", want.active, got.active);
					compare_field("pred_mask", want.pred, got.pred);
					compare_field("lane_digest", 64'(want.digest), 64'(got.digest));
					compare_field("stack_level", 64'(want.level), 64'(got.level));
					compare_field("error", 64'(want.err), 64'(got.err));
					compared++;
				end
			end
			if (cfg_wen)
				lane_cnt = cfg_wdata;
			if (s_tvalid && s_tready)
				status_q.push_back(step_warp(s_tdata));
			fail_count <= fails;
			pending    <= status_q.size();
			checked    <= compared;
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the simt active mask stack
// ----------------------------------------------------------------------------
// a short directed run covers field extremes, every operation,
// underflow, out of range lanes and inactive digest updates; then phases of
// random requests follow, each under its own lane count and push bias so
// that the stack climbs to the top and falls back to the bottom. both sides
// stall at random except in one quiet phase.
// ----------------------------------------------------------------------------
module testbench;
	import sams_pkg::*;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam int         PHASES     = 8;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         cfg_wen       = 1'b0;
	logic [6:0]   cfg_wdata     = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [79:0]  s_axis_tdata  = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [167:0] m_axis_tdata;
	logic         quiet         = 1'b0;
	int           fail_count;
	int           pending;
	int           checked;
	int           sent          = 0;
	int           settings      = 0;
	int           cur_lanes     = 64;

	simt_active_mask_stack DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	mask_stack_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(99) >= 36);
	end

	task automatic send_req(input logic [2:0] op, input logic [5:0] lane, input logic bitv,
			input logic [4:0] cnt, input logic [31:0] icount, input logic [31:0] iaddr);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 36) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, iaddr, icount, cnt, bitv, lane, op};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	// hold off until every outstanding request has its result
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_lanes(input logic [6:0] value);
		drain();
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen   <= 1'b0;
		cur_lanes = int'(value);
		settings++;
	endtask

	task automatic random_req(input int push_pct);
		int         r;
		int         in_use;
		logic [2:0] op;
		logic [5:0] lane;
		logic [4:0] cnt;
		logic       bitv;
		in_use = (cur_lanes < 64) ? cur_lanes : 64;
		if ($urandom_range(99) < push_pct) begin
			op = OP_PUSH;
		end else begin
			r = $urandom_range(79);
			if (r < 15)
				op = OP_POP;
			else if (r < 35)
				op = OP_SETACT;
			else if (r < 48)
				op = OP_SETPRD;
			else if (r < 72)
				op = OP_DIGEST;
			else if (r < 76)
				op = OP_QUERY;
			else if (r < 78)
				op = OP_SPARE_A;
			else
				op = OP_SPARE_B;
		end
		if (in_use > 0 && $urandom_range(99) < 85)
			lane = 6'($urandom_range(in_use - 1));
		else
			lane = 6'($urandom_range(63));
		if (op == OP_SETACT)
			bitv = ($urandom_range(99) < 75);
		else
			bitv = 1'($urandom_range(1));
		if (op == OP_POP && $urandom_range(99) < 90)
			cnt = 5'($urandom_range(2));
		else
			cnt = 5'($urandom_range(31));
		send_req(op, lane, bitv, cnt, $urandom(), $urandom());
	endtask

	initial begin
		logic [6:0] lane_set [PHASES];
		int         push_bias [PHASES];
		int         n_items;
		lane_set  = '{7'd64, 7'd0, 7'd127, 7'd33, 7'd1, 7'd65, 7'd64, 7'd64};
		push_bias = '{10, 30, 45, 60, 35, 45, 25, 50};
		lane_set[6] = 7'($urandom_range(1, 64));
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes and the special cases other than overflow
		send_req(OP_QUERY, 6'd0, 1'b0, 5'd0, 32'd0, 32'd0);
		send_req(OP_SETACT, 6'd0, 1'b1, 5'd0, 32'd0, 32'd0);
		send_req(OP_SETACT, 6'd63, 1'b1, 5'd31, '1, '1);
		send_req(OP_SETPRD, 6'd63, 1'b1, 5'd0, 32'd0, 32'd0);
		send_req(OP_SETPRD, 6'd0, 1'b1, 5'd0, 32'd0, 32'd0);
		send_req(OP_SETPRD, 6'd0, 1'b0, 5'd0, 32'd0, 32'd0);
		send_req(OP_DIGEST, 6'd0, 1'b0, 5'd0, '1, '1);
		send_req(OP_DIGEST, 6'd63, 1'b1, 5'd31, 32'd0, 32'd0);
		send_req(OP_DIGEST, 6'd63, 1'b0, 5'd0, 32'h8000_0001, 32'h7fff_fffe);
		send_req(OP_DIGEST, 6'd5, 1'b0, 5'd0, 32'h1234_5678, 32'h9abc_def0);
		send_req(OP_PUSH, 6'd0, 1'b0, 5'd0, 32'd0, 32'd0);
		send_req(OP_SETACT, 6'd0, 1'b0, 5'd0, 32'd0, 32'd0);
		send_req(OP_DIGEST, 6'd0, 1'b0, 5'd0, '1, 32'd1);
		send_req(OP_POP, 6'd0, 1'b0, 5'd0, 32'd0, 32'd0);
		send_req(OP_POP, 6'd0, 1'b0, 5'd1, 32'd0, 32'd0);
		send_req(OP_POP, 6'd0, 1'b0, 5'd1, 32'd0, 32'd0);
		send_req(OP_POP, 6'd63, 1'b1, 5'd31, 32'd0, 32'd0);
		send_req(OP_QUERY, 6'd63, 1'b1, 5'd0, 32'd0, 32'd0);
		send_req(OP_SPARE_A, 6'd63, 1'b1, 5'd31, '1, '1);
		send_req(OP_SPARE_B, 6'd0, 1'b0, 5'd0, 32'd0, 32'd0);
		write_lanes(7'd1);
		send_req(OP_SETACT, 6'd1, 1'b1, 5'd0, 32'd0, 32'd0);
		send_req(OP_SETPRD, 6'd32, 1'b1, 5'd0, 32'd0, 32'd0);
		send_req(OP_DIGEST, 6'd63, 1'b0, 5'd0, '1, '1);
		send_req(OP_SETACT, 6'd0, 1'b0, 5'd0, 32'd0, 32'd0);
		send_req(OP_QUERY, 6'd0, 1'b0, 5'd0, 32'd0, 32'd0);

		// random phases, one lane count each
		for (int p = 0; p < PHASES; p++) begin
			write_lanes(lane_set[p]);
			quiet   = (p == 3);
			n_items = (lane_set[p] == 7'd0) ? 100 : 200;
			for (int i = 0; i < n_items; i++) begin
				if (p == 5 && i == n_items / 2)
					drain();
				random_req(push_bias[p]);
			end
			quiet = 1'b0;
		end

		drain();
		$display("ran %0d requests under %0d lane count settings, %0d results compared",
			sent, settings, checked);
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#400000;
		$display("testbench: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/sams_pkg.sv
src/sams_ram.sv
src/sams_mask_stack.sv
src/sams_digest.sv
src/simt_active_mask_stack.sv
tb/mask_stack_checker.sv
tb/testbench.sv
